// File: hdl/svm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types and constants of the stack machine instruction executor.
// ----------------------------------------------------------------------------
package svm_pkg;

    localparam int VALUE_DEPTH    = 16;
    localparam int RETURN_DEPTH   = 8;
    localparam int VARIABLE_COUNT = 26;
    localparam int WORD_WIDTH     = 32;
    localparam int VP_W  = $clog2(VALUE_DEPTH);
    localparam int VC_W  = $clog2(VALUE_DEPTH + 1);
    localparam int RP_W  = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
    localparam int RC_W  = $clog2(RETURN_DEPTH + 1);
    localparam int VI_W  = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;
    localparam int DC_W  = $clog2(WORD_WIDTH + 1);

    typedef logic [WORD_WIDTH-1:0] word_t;

    typedef enum logic [4:0] {
        OP_MODE = 5'd0, OP_SET = 5'd1, OP_WAIT = 5'd2, OP_JMP = 5'd3,
        OP_HALT = 5'd4, OP_NOP = 5'd5, OP_PUSH = 5'd6, OP_LOAD = 5'd7,
        OP_SAVE = 5'd8, OP_READ = 5'd9, OP_ADD = 5'd10, OP_SUB = 5'd11,
        OP_MUL = 5'd12, OP_DIV = 5'd13, OP_GT = 5'd14, OP_LT = 5'd15,
        OP_EQ = 5'd16, OP_AND = 5'd17, OP_NOT = 5'd18, OP_ABS = 5'd19,
        OP_JZ = 5'd20, OP_CALL = 5'd21, OP_RET = 5'd22, OP_TONE = 5'd23,
        OP_RPIN = 5'd24, OP_ANGLE = 5'd25, OP_ADC = 5'd26, OP_MOVE = 5'd27,
        OP_CLS_ON = 5'd28, OP_CLASSIFY = 5'd29, OP_RSV30 = 5'd30, OP_RSV31 = 5'd31
    } opcode_t;

    localparam logic [1:0] RS_IDLE = 2'd0, RS_RUN = 2'd1, RS_WAIT = 2'd2, RS_STOP = 2'd3;
    localparam logic [3:0] ACT_NONE = 4'd0, ACT_PIN_MODE = 4'd1, ACT_PIN_WRITE = 4'd2,
        ACT_TONE_ON = 4'd3, ACT_TONE_OFF = 4'd4, ACT_SERVO = 4'd5, ACT_MOVE = 4'd6,
        ACT_STOP = 4'd7, ACT_REPORT = 4'd8;
    localparam logic [1:0] ST_OK = 2'd0, ST_HALT = 2'd1, ST_RET_OVF = 2'd2, ST_UNIMPL = 2'd3;

    typedef enum logic [2:0] {
        C_IDLE, C_POP_Y, C_POP_X, C_MUL, C_DIV, C_EXEC, C_OUT
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input word
        logic pop_y;     // pop into y
        logic pop_x;     // pop into x
        logic mul;       // register product
        logic div_start;
        logic div_step;
        logic exec;      // commit instruction, fill result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic two_pop;
        logic one_pop;
        logic is_mul;
        logic is_div;
        logic div_last;
    } dp_status_t;

endpackage
`default_nettype wire

// File: hdl/stack_vm_instruction_executor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stack_vm_instruction_executor_core
// Executes one stack machine instruction per input word.
// ----------------------------------------------------------------------------
// One word in, one word out, one instruction at a time. An accepted word
// goes through the pop states, then through a product register for mul or a
// bit-serial restoring divider of one quotient bit per cycle for div, then
// commit and delivery. The next word is taken once the result has been
// delivered.
module stack_vm_instruction_executor_core (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire logic [4:0] kind,
    input  wire logic signed [31:0] operand_a,
    input  wire logic signed [31:0] operand_b,
    input  wire logic signed [31:0] sensed_value,
    input  wire logic model_is_vision,
    output logic out_valid,
    input  wire logic out_stall,
    output logic [15:0] next_pc,
    output logic [1:0] run_state,
    output logic [3:0] action,
    output logic signed [31:0] action_first,
    output logic signed [31:0] action_second,
    output logic [31:0] wait_ms,
    output logic signed [31:0] top_value,
    output logic [1:0] status,
    output logic voice_requested,
    output logic vision_requested
);
    import svm_pkg::*;

    dp_cmd_t cmd;
    dp_status_t stat;

    // sequencer
    svm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
    );

    // datapath
    svm_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .kind(kind), .operand_a(operand_a), .operand_b(operand_b),
        .sensed_value(sensed_value), .model_is_vision(model_is_vision),
        .next_pc(next_pc), .run_state(run_state), .action(action),
        .action_first(action_first), .action_second(action_second),
        .wait_ms(wait_ms), .top_value(top_value), .status(status),
        .voice_requested(voice_requested), .vision_requested(vision_requested)
    );

endmodule
`default_nettype wire

// File: hdl/svm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svm_ctrl
// Sequencer: accept a word, pop operands, run mul or divide, commit, deliver.
// ----------------------------------------------------------------------------
module svm_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  wire logic out_stall,
    output svm_pkg::dp_cmd_t cmd,
    input  wire svm_pkg::dp_status_t stat
);
    import svm_pkg::*;

    ctl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= C_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = C_POP_Y;
                end
            end
            C_POP_Y:
            begin
                if (stat.two_pop || stat.one_pop)
                begin
                    cmd.pop_y = 1'b1;
                    state_next = stat.two_pop ? C_POP_X : C_EXEC;
                end
                else
                    state_next = C_EXEC;
            end
            C_POP_X:
            begin
                cmd.pop_x = 1'b1;
                if (stat.is_mul)
                    state_next = C_MUL;
                else if (stat.is_div)
                begin
                    state_next = C_DIV;
                end
                else
                    state_next = C_EXEC;
            end
            C_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = C_EXEC;
            end
            C_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = C_EXEC;
            end
            C_EXEC:
            begin
                cmd.exec = 1'b1;
                state_next = C_OUT;
            end
            C_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
        cmd.div_start = (state_reg == C_POP_X) && stat.is_div;
    end

endmodule
`default_nettype wire

// File: hdl/svm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svm_datapath
// Stacks, variables, pc, bit-serial divider and result registers.
// ----------------------------------------------------------------------------
module svm_datapath (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire svm_pkg::dp_cmd_t cmd,
    output svm_pkg::dp_status_t stat,
    input  wire logic [4:0] kind,
    input  wire logic signed [31:0] operand_a,
    input  wire logic signed [31:0] operand_b,
    input  wire logic signed [31:0] sensed_value,
    input  wire logic model_is_vision,
    output logic [15:0] next_pc,
    output logic [1:0] run_state,
    output logic [3:0] action,
    output logic signed [31:0] action_first,
    output logic signed [31:0] action_second,
    output logic [31:0] wait_ms,
    output logic signed [31:0] top_value,
    output logic [1:0] status,
    output logic voice_requested,
    output logic vision_requested
);
    import svm_pkg::*;

    // captured input word
    opcode_t op_reg;
    logic [31:0] a_reg, b_reg, s_reg;
    logic vis_reg;

    // machine state
    logic [15:0] pc_reg;
    logic [VC_W-1:0] vcnt_reg;
    logic [RC_W-1:0] rcnt_reg;
    logic [1:0] ms_reg;
    logic voice_reg, vision_reg;
    word_t vstore [VALUE_DEPTH];
    logic [15:0] rstore [RETURN_DEPTH];
    word_t vars_reg [VARIABLE_COUNT];
    word_t top_reg;

    // operands and units
    word_t x_reg, y_reg, prod_reg;
    word_t dq_reg, dr_reg, dd_reg;
    logic [DC_W-1:0] dcnt_reg;
    logic dneg_reg;

    // command decode
    always_comb
    begin
        stat.two_pop = (op_reg inside {[OP_ADD:OP_AND]});
        stat.one_pop = (op_reg inside {OP_NOT, OP_ABS, OP_JZ, OP_SAVE});
        stat.is_mul = (op_reg == OP_MUL);
        stat.is_div = (op_reg == OP_DIV);
        stat.div_last = (dcnt_reg == DC_W'(1));
    end

    // pop read
    logic vempty;
    word_t pop_val;
    logic [VP_W-1:0] pop_idx;
    assign vempty = (vcnt_reg == '0);
    assign pop_idx = VP_W'(vcnt_reg - VC_W'(1));
    assign pop_val = vempty ? '0 : vstore[pop_idx];

    // sign-extended input operands
    word_t wa, ws;
    assign wa = WORD_WIDTH'(signed'(a_reg));
    assign ws = WORD_WIDTH'(signed'(s_reg));
    logic idx_ok;
    assign idx_ok = !a_reg[31] && (a_reg < 32'(VARIABLE_COUNT));
    logic [VI_W-1:0] vidx;
    assign vidx = VI_W'(a_reg);

    // divider remainder step
    word_t ay;
    assign ay = y_reg[WORD_WIDTH-1] ? (-y_reg) : y_reg;
    logic [WORD_WIDTH:0] dtrial;
    assign dtrial = {dr_reg, dq_reg[WORD_WIDTH-1]} - {1'b0, dd_reg};

    // execute: push value and control
    logic do_push;
    word_t push_val;
    logic [15:0] pc_inc, pc_new;
    logic [1:0] ms_new, st_new;
    logic [3:0] act_new;
    word_t f_new, s_new_arg;
    logic [31:0] w_new;
    logic rpush, rpop;
    always_comb
    begin
        pc_inc = pc_reg + 16'd1;
        pc_new = pc_inc;
        do_push = 1'b0;
        push_val = '0;
        ms_new = ms_reg;
        st_new = ST_OK;
        act_new = ACT_NONE;
        f_new = '0;
        s_new_arg = '0;
        w_new = '0;
        rpush = 1'b0;
        rpop = 1'b0;
        case (op_reg)
            OP_MODE: begin act_new = ACT_PIN_MODE; f_new = a_reg; s_new_arg = b_reg; end
            OP_SET:
            begin
                act_new = ACT_PIN_WRITE; f_new = a_reg;
                s_new_arg = {31'd0, (b_reg != 32'd0)};
            end
            OP_WAIT: begin w_new = a_reg; ms_new = RS_WAIT; end
            OP_JMP: pc_new = a_reg[15:0];
            OP_HALT: begin ms_new = RS_STOP; act_new = ACT_STOP; st_new = ST_HALT; end
            OP_NOP: ;
            OP_PUSH: begin do_push = 1'b1; push_val = wa; end
            OP_LOAD: begin do_push = 1'b1; push_val = idx_ok ? vars_reg[vidx] : '0; end
            OP_SAVE: ;
            OP_READ, OP_ADC: begin do_push = 1'b1; push_val = ws; end
            OP_ADD: begin do_push = 1'b1; push_val = x_reg + y_reg; end
            OP_SUB: begin do_push = 1'b1; push_val = x_reg - y_reg; end
            OP_MUL: begin do_push = 1'b1; push_val = prod_reg; end
            OP_DIV: begin do_push = 1'b1; push_val = dneg_reg ? -dq_reg : dq_reg; end
            OP_GT:
            begin
                do_push = 1'b1;
                push_val = WORD_WIDTH'($signed(y_reg) < $signed(x_reg));
            end
            OP_LT:
            begin
                do_push = 1'b1;
                push_val = WORD_WIDTH'($signed(x_reg) < $signed(y_reg));
            end
            OP_EQ: begin do_push = 1'b1; push_val = WORD_WIDTH'(x_reg == y_reg); end
            OP_AND:
            begin
                do_push = 1'b1;
                push_val = WORD_WIDTH'((x_reg != '0) && (y_reg != '0));
            end
            OP_NOT: begin do_push = 1'b1; push_val = WORD_WIDTH'(y_reg == '0); end
            OP_ABS: begin do_push = 1'b1; push_val = ay; end
            OP_JZ: if (y_reg == '0) pc_new = a_reg[15:0];
            OP_CALL:
            begin
                if (rcnt_reg < RC_W'(RETURN_DEPTH))
                begin
                    rpush = 1'b1;
                    pc_new = a_reg[15:0];
                end
                else
                begin
                    ms_new = RS_STOP; act_new = ACT_STOP; st_new = ST_RET_OVF;
                end
            end
            OP_RET:
            begin
                if (rcnt_reg != '0)
                begin
                    rpop = 1'b1;
                    pc_new = rstore[RP_W'(rcnt_reg - RC_W'(1))];
                end
            end
            OP_TONE:
            begin
                f_new = a_reg;
                if (b_reg != 32'd0 && !b_reg[31])
                begin
                    act_new = ACT_TONE_ON; s_new_arg = b_reg;
                end
                else
                    act_new = ACT_TONE_OFF;
            end
            OP_RPIN: begin act_new = ACT_REPORT; f_new = a_reg; s_new_arg = s_reg; end
            OP_ANGLE: begin act_new = ACT_SERVO; f_new = a_reg; s_new_arg = b_reg; end
            OP_MOVE: begin act_new = ACT_MOVE; f_new = a_reg; s_new_arg = b_reg; end
            OP_CLS_ON: ;
            OP_CLASSIFY: begin do_push = 1'b1; push_val = ws; end
            default: st_new = ST_UNIMPL;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
            vcnt_reg <= '0;
            rcnt_reg <= '0;
            ms_reg <= RS_IDLE;
            voice_reg <= 1'b0;
            vision_reg <= 1'b0;
            for (int i = 0; i < VARIABLE_COUNT; i++)
                vars_reg[i] <= '0;
        end
        else
        begin
            if (cmd.pop_y || cmd.pop_x)
                if (!vempty)
                    vcnt_reg <= vcnt_reg - VC_W'(1);
            if (cmd.exec)
            begin
                pc_reg <= pc_new;
                ms_reg <= ms_new;
                if (do_push && vcnt_reg < VC_W'(VALUE_DEPTH))
                    vcnt_reg <= vcnt_reg + VC_W'(1);
                if (rpush)
                    rcnt_reg <= rcnt_reg + RC_W'(1);
                if (rpop)
                    rcnt_reg <= rcnt_reg - RC_W'(1);
                if (op_reg == OP_SAVE && idx_ok)
                    vars_reg[vidx] <= y_reg;
                if (op_reg == OP_CLS_ON || op_reg == OP_CLASSIFY)
                begin
                    if (vis_reg)
                        vision_reg <= 1'b1;
                    else
                        voice_reg <= 1'b1;
                end
            end
        end
    end

    // stacks, operands, divider, results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= opcode_t'(kind);
            a_reg <= operand_a;
            b_reg <= operand_b;
            s_reg <= sensed_value;
            vis_reg <= model_is_vision;
        end
        if (cmd.pop_y)
            y_reg <= pop_val;
        if (cmd.pop_x)
            x_reg <= pop_val;
        if (cmd.mul)
            prod_reg <= x_reg * y_reg;
        if (cmd.div_start)
        begin
            // x is being popped this cycle
            dq_reg <= pop_val[WORD_WIDTH-1] ? -pop_val : pop_val;
            dr_reg <= '0;
            dd_reg <= ay;
            dcnt_reg <= DC_W'(WORD_WIDTH);
            dneg_reg <= pop_val[WORD_WIDTH-1] ^ y_reg[WORD_WIDTH-1];
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg - DC_W'(1);
            if (dd_reg == '0)
            begin
                dq_reg <= '0;
                dr_reg <= '0;
            end
            else if (!dtrial[WORD_WIDTH])
            begin
                dr_reg <= dtrial[WORD_WIDTH-1:0];
                dq_reg <= {dq_reg[WORD_WIDTH-2:0], 1'b1};
            end
            else
            begin
                dr_reg <= {dr_reg[WORD_WIDTH-2:0], dq_reg[WORD_WIDTH-1]};
                dq_reg <= {dq_reg[WORD_WIDTH-2:0], 1'b0};
            end
        end
        if (cmd.exec)
        begin
            if (do_push && vcnt_reg < VC_W'(VALUE_DEPTH))
            begin
                vstore[VP_W'(vcnt_reg)] <= push_val;
                top_reg <= push_val;
            end
            else
                top_reg <= vempty ? '0 : vstore[pop_idx];
            if (rpush)
                rstore[RP_W'(rcnt_reg)] <= pc_inc;
            next_pc <= pc_new;
            run_state <= ms_new;
            action <= act_new;
            action_first <= f_new[31:0];
            action_second <= s_new_arg[31:0];
            wait_ms <= w_new;
            status <= st_new;
        end
    end

    // flags and top of stack
    always_comb
    begin
        voice_requested = voice_reg;
        vision_requested = vision_reg;
        top_value = top_reg[31:0];
    end

endmodule
`default_nettype wire
